// ===== sv/ghash_gf128_multiplier_unit_assert.svh =====
// assertion macros for the ghash gf128 multiplier unit checker
`ifndef GHASH_GF128_MULTIPLIER_UNIT_ASSERT_SVH
`define GHASH_GF128_MULTIPLIER_UNIT_ASSERT_SVH

// same-cycle implication, ignored while reset is low
`define GHM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ghm assertion failed");

// next-cycle implication, ignored while reset is low
`define GHM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ghm assertion failed");

// next-cycle implication that also holds across reset
`define GHM_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ghm assertion failed");

`endif

// ===== sv/ghm_pkg.sv =====
// shared widths, types, constants and gf(2^128) helper functions
package ghm_pkg;

    localparam int BLK_W        = 128;
    localparam int HALF_W       = 64;
    localparam int NIB_W        = 4;
    localparam int RED_W        = 16;
    localparam int NUM_NIBS     = BLK_W / NIB_W;
    localparam int NIBS_PER_STG = 4;
    localparam int CFG_IDX_W    = 2;

    typedef logic [BLK_W-1:0]     t_blk;
    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [NIB_W-1:0]     t_nib;
    typedef logic [RED_W-1:0]     t_red;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_KEY_HIGH = t_cfg_idx'(0);
    localparam t_cfg_idx REG_KEY_LOW  = t_cfg_idx'(1);

    // reduction byte of x^128 + x^7 + x^2 + x + 1 in reflected order
    localparam logic [7:0] R_BYTE = 8'he1;
    localparam t_blk       R_POLY = {R_BYTE, {(BLK_W-8){1'b0}}};

    // folds the nibble shifted out of the low end back into the top
    localparam t_red REDUCE4 [16] = '{
        16'h0000, 16'h1c20, 16'h3840, 16'h2460,
        16'h7080, 16'h6ca0, 16'h48c0, 16'h54e0,
        16'he100, 16'hfd20, 16'hd940, 16'hc560,
        16'h9180, 16'h8da0, 16'ha9c0, 16'hb5e0
    };

    // the four key multiples that span the nibble table
    typedef struct packed {
        t_blk m8;   // h
        t_blk m4;   // h * x
        t_blk m2;   // h * x^2
        t_blk m1;   // h * x^3
    } t_basis;

    function automatic t_blk mul_x(t_blk v);
        return (v >> 1) ^ (v[0] ? R_POLY : '0);
    endfunction

    function automatic t_basis build_basis(t_blk h);
        t_basis b;
        b.m8 = h;
        b.m4 = mul_x(b.m8);
        b.m2 = mul_x(b.m4);
        b.m1 = mul_x(b.m2);
        return b;
    endfunction

    // table entry n, nibble read in gcm bit order
    function automatic t_blk nib_mult(t_basis b, t_nib n);
        return (n[3] ? b.m8 : '0) ^ (n[2] ? b.m4 : '0) ^
               (n[1] ? b.m2 : '0) ^ (n[0] ? b.m1 : '0);
    endfunction

    // one shoup step: shift right a nibble, reduce, add the next multiple
    function automatic t_blk shift_add(t_blk z, t_nib n, t_basis b);
        t_blk r;
        r = z >> NIB_W;
        r[BLK_W-1 -: RED_W] = r[BLK_W-1 -: RED_W] ^ REDUCE4[z[NIB_W-1:0]];
        return r ^ nib_mult(b, n);
    endfunction

endpackage

// ===== sv/ghm_if.sv =====
// valid/ready channel interfaces for blocks, products and key writes
interface ghm_blk_if;
    import ghm_pkg::*;
    logic  valid;
    logic  ready;
    t_half block_high;
    t_half block_low;
    modport source (output valid, output block_high, output block_low, input ready);
    modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface ghm_prod_if;
    import ghm_pkg::*;
    logic  valid;
    logic  ready;
    t_half product_high;
    t_half product_low;
    modport source (output valid, output product_high, output product_low, input ready);
    modport sink   (input valid, input product_high, input product_low, output ready);
endinterface

interface ghm_cfg_if;
    import ghm_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_half    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ghash_gf128_multiplier_unit.sv =====
// ghash gf(2^128) block-times-key multiplier, shoup 4-bit method, pipelined
// a block passes through the stages in order; the last stage holds the finished product
// one block per cycle unless stalled; each stage runs P_NIBS_PER_STG shift-add steps
// stages stall independently, so bubbles fill while a finished product waits
// a key write updates the multiples table at its own edge, the next block already uses it
// synchronous active-low reset clears key (products read zero) and all valid bits
module ghash_gf128_multiplier_unit #(
    parameter int P_NIBS_PER_STG = ghm_pkg::NIBS_PER_STG
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ghm_cfg_if.sink     i_cfg,
    ghm_blk_if.sink     i_blk,
    ghm_prod_if.source  o_prod
);
    import ghm_pkg::*;

    localparam int NUM_STG = NUM_NIBS / P_NIBS_PER_STG;

    // key halves and the derived multiples of h
    t_half  r_key_high;
    t_half  r_key_low;
    t_half  n_key_high;
    t_half  n_key_low;
    t_basis r_basis;

    // pipeline: accumulator, operand and valid per stage
    t_blk   r_z [NUM_STG];
    t_blk   r_x [NUM_STG];
    logic   r_v [NUM_STG];
    logic [NUM_STG:0] w_rdy;

    // key writes, unknown index leaves everything as is
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_key_high = r_key_high;
        n_key_low  = r_key_low;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KEY_HIGH: n_key_high = i_cfg.data;
                REG_KEY_LOW:  n_key_low  = i_cfg.data;
                default: ;
            endcase
        end
    end

    // key and its multiples table change together at the write edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_basis    <= '0;
        end else begin
            r_key_high <= n_key_high;
            r_key_low  <= n_key_low;
            r_basis    <= build_basis({n_key_high, n_key_low});
        end
    end

    // a stage takes new data when empty or when its successor moves
    assign w_rdy[NUM_STG] = o_prod.ready;
    assign i_blk.ready    = w_rdy[0];

    for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
        t_blk w_z_in;
        t_blk w_x_in;
        logic w_v_in;
        t_blk n_z;

        if (s == 0) begin : g_first
            // first nibble processed is the low nibble of byte 15
            assign w_z_in = '0;
            assign w_x_in = {i_blk.block_high, i_blk.block_low};
            assign w_v_in = i_blk.valid;
        end else begin : g_next
            assign w_z_in = r_z[s-1];
            assign w_x_in = r_x[s-1];
            assign w_v_in = r_v[s-1];
        end

        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];

        // nibble k of the walk sits at bits 4k+3:4k of the block
        always_comb begin
            n_z = w_z_in;
            for (int j = 0; j < P_NIBS_PER_STG; j++) begin
                n_z = shift_add(n_z, w_x_in[NIB_W*(s*P_NIBS_PER_STG + j) +: NIB_W],
                                r_basis);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_v_in) begin
                r_z[s] <= n_z;
                r_x[s] <= w_x_in;
            end
        end
    end

    // last stage is the output register
    assign o_prod.valid        = r_v[NUM_STG-1];
    assign o_prod.product_high = r_z[NUM_STG-1][BLK_W-1 -: HALF_W];
    assign o_prod.product_low  = r_z[NUM_STG-1][HALF_W-1:0];

endmodule

// ===== sv/ghm_checker.sv =====
// port-level checker for the ghash multiplier and its bind
`include "ghash_gf128_multiplier_unit_assert.svh"

module ghm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_blk_ready,
    input logic                i_prod_valid,
    input logic                i_prod_ready,
    input ghm_pkg::t_half      i_prod_high,
    input ghm_pkg::t_half      i_prod_low,
    input logic                i_cfg_ready
);
    // nothing leaves the pipe right after reset
    `GHM_ASSERT_RST(a_rst_empty, !i_rst_n, !i_prod_valid)
    // key writes are never back-pressured
    `GHM_ASSERT_IMP(a_cfg_ready, 1'b1, i_cfg_ready)
    // with no product pending the pipe always has room
    `GHM_ASSERT_IMP(a_room, !i_prod_valid, i_blk_ready)
    // a stalled product stays put
    `GHM_ASSERT_NXT(a_hold, i_prod_valid && !i_prod_ready,
        i_prod_valid && $stable(i_prod_high) && $stable(i_prod_low))
endmodule

bind ghash_gf128_multiplier_unit ghm_checker u_ghm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_blk_ready  (i_blk.ready),
    .i_prod_valid (o_prod.valid),
    .i_prod_ready (o_prod.ready),
    .i_prod_high  (o_prod.product_high),
    .i_prod_low   (o_prod.product_low),
    .i_cfg_ready  (i_cfg.ready)
);

// ===== tb/ghm_product_checker.sv =====
// product checker for the ghash gf128 multiplier: tracks the key, predicts and compares products
module ghm_product_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ghm_cfg_if   cfg,
    ghm_blk_if   blk,
    ghm_prod_if  prod,
    output int   o_fail_count,
    output int   o_products_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import ghm_pkg::*;

    localparam logic [7:0] POLY_BYTE = 8'he1;

    // folds a nibble shifted out of the low end back into the top 16 bits
    localparam logic [15:0] NIB_FOLD [16] = '{
        16'h0000, 16'h1c20, 16'h3840, 16'h2460,
        16'h7080, 16'h6ca0, 16'h48c0, 16'h54e0,
        16'he100, 16'hfd20, 16'hd940, 16'hc560,
        16'h9180, 16'h8da0, 16'ha9c0, 16'hb5e0
    };

    t_half key_hi;
    t_half key_lo;
    t_blk  h_multiple [16];
    t_blk  expected_products [$];
    int    fail_count;
    int    products_seen;

    assign o_fail_count    = fail_count;
    assign o_products_seen = products_seen;

    initial begin
        fail_count    = 0;
        products_seen = 0;
    end

    // multiply by x in reflected bit order
    function automatic t_blk times_x(t_blk v);
        return (v >> 1) ^ (v[0] ? {POLY_BYTE, {(BLK_W-8){1'b0}}} : '0);
    endfunction

    function void rebuild_multiples();
        h_multiple[0] = '0;
        h_multiple[8] = {key_hi, key_lo};
        h_multiple[4] = times_x(h_multiple[8]);
        h_multiple[2] = times_x(h_multiple[4]);
        h_multiple[1] = times_x(h_multiple[2]);
        for (int n = 2; n <= 8; n *= 2)
            for (int m = 1; m < n; m++)
                h_multiple[n+m] = h_multiple[n] ^ h_multiple[m];
    endfunction

    // nibbles from the last byte up, low nibble of each byte first
    function automatic t_blk gf_times_key(t_blk x);
        t_blk acc;
        t_nib spill;
        acc = h_multiple[x[3:0]];
        for (int k = 1; k < NUM_NIBS; k++) begin
            spill = acc[3:0];
            acc = acc >> NIB_W;
            acc[BLK_W-1 -: 16] = acc[BLK_W-1 -: 16] ^ NIB_FOLD[spill];
            acc = acc ^ h_multiple[x[NIB_W*k +: NIB_W]];
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin : watch
        t_blk want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            rebuild_multiples();
            expected_products.delete();
        end else begin
            if (prod.valid && prod.ready) begin
                products_seen++;
                if (expected_products.size() == 0) begin
                    $error("unexpected product beat: product_high=%h product_low=%h",
                           prod.product_high, prod.product_low);
                    fail_count++;
                end else begin
                    want = expected_products.pop_front();
                    if (prod.product_high !== want[BLK_W-1 -: HALF_W]) begin
                        $error("product_high mismatch: expected %h, actual %h",
                               want[BLK_W-1 -: HALF_W], prod.product_high);
                        fail_count++;
                    end
                    if (prod.product_low !== want[HALF_W-1:0]) begin
                        $error("product_low mismatch: expected %h, actual %h",
                               want[HALF_W-1:0], prod.product_low);
                        fail_count++;
                    end
                end
            end
            if (blk.valid && blk.ready)
                expected_products.push_back(gf_times_key({blk.block_high, blk.block_low}));
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_KEY_HIGH: begin
                        key_hi = cfg.data;
                        rebuild_multiples();
                    end
                    REG_KEY_LOW: begin
                        key_lo = cfg.data;
                        rebuild_multiples();
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// top of the ghash gf128 multiplier testbench: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ghm_pkg::*;

    // register indexes the block does not decode; writes there must be dropped
    localparam t_cfg_idx REG_SPARE_2 = t_cfg_idx'(2);
    localparam t_cfg_idx REG_SPARE_3 = t_cfg_idx'(3);

    localparam int IDLE_PCT      = 8;     // chance of a gap or stall per cycle
    localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int RANDOM_BLOCKS = 500;
    localparam int KEY_PHASES    = 5;
    localparam int QUIET_PHASE   = 2;     // phase that runs with no gaps or stalls
    localparam int SETTLE_CYCLES = 20;    // pipeline is 8 deep, leave some slack

    typedef struct packed {
        t_cfg_idx idx;
        t_half    val;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    ghm_cfg_if  cfg_if ();
    ghm_blk_if  blk_if ();
    ghm_prod_if prod_if ();

    int         fail_count;
    int         products_seen;
    int         blocks_sent;
    int         idle_cycles;
    bit         quiet;
    t_reg_write write_plan [$];

    ghash_gf128_multiplier_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_blk   (blk_if),
        .o_prod  (prod_if)
    );

    ghm_product_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .cfg             (cfg_if),
        .blk             (blk_if),
        .prod            (prod_if),
        .o_fail_count    (fail_count),
        .o_products_seen (products_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // product sink: random stalls unless in the quiet stretch
    always @(posedge i_clk) begin
        prod_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (blk_if.valid && blk_if.ready) || (prod_if.valid && prod_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one operand beat, with an occasional gap in front; valid stays high afterwards
    task automatic send_block(input t_blk x);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            blk_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        blk_if.valid      <= 1'b1;
        blk_if.block_high <= x[BLK_W-1 -: HALF_W];
        blk_if.block_low  <= x[HALF_W-1:0];
        do @(posedge i_clk); while (!blk_if.ready);
        blocks_sent++;
    endtask

    // hold off new blocks until every product is back
    task automatic wait_drained();
        blk_if.valid <= 1'b0;
        while (products_seen != blocks_sent) @(posedge i_clk);
    endtask

    task automatic plan_write(input t_cfg_idx idx, input t_half val);
        write_plan.push_back('{idx: idx, val: val});
    endtask

    // key writes only go out with the pipeline empty; the plan is never empty here
    task automatic apply_writes();
        wait_drained();
        foreach (write_plan[i]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= write_plan[i].idx;
            cfg_if.data  <= write_plan[i].val;
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        write_plan.delete();
    endtask

    function automatic t_blk random_wide();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // mostly dense random data, some zero, all-ones and single-bit operands
    function automatic t_blk random_block();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return t_blk'(1) << $urandom_range(BLK_W-1);
            default: return random_wide();
        endcase
    endfunction

    // new key for a random phase: sometimes only half of it, sometimes a stray write too
    task automatic new_key_phase();
        t_blk key;
        case ($urandom_range(5))
            0:       key = '0;
            1:       key = '1;
            2:       key = t_blk'(1) << $urandom_range(BLK_W-1);
            default: key = random_wide();
        endcase
        case ($urandom_range(3))
            0: plan_write(REG_KEY_HIGH, key[BLK_W-1 -: HALF_W]);
            1: plan_write(REG_KEY_LOW, key[HALF_W-1:0]);
            2: begin
                plan_write(REG_KEY_LOW, key[HALF_W-1:0]);
                plan_write(REG_KEY_HIGH, key[BLK_W-1 -: HALF_W]);
            end
            default: begin
                plan_write(REG_KEY_HIGH, key[BLK_W-1 -: HALF_W]);
                plan_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
                plan_write(REG_KEY_LOW, key[HALF_W-1:0]);
            end
        endcase
        apply_writes();
    endtask

    initial begin : stimulus
        blocks_sent = 0;
        quiet       = 1'b0;

        i_rst_n           <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_KEY_HIGH;
        cfg_if.data       <= '0;
        blk_if.valid      <= 1'b0;
        blk_if.block_high <= '0;
        blk_if.block_low  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key is zero straight out of reset, so products must read zero
        send_block('1);
        send_block({1'b1, {(BLK_W-1){1'b0}}});

        // full key, then the operand extremes and every nibble value
        plan_write(REG_KEY_HIGH, 64'h66e94bd4ef8a2c3b);
        plan_write(REG_KEY_LOW, 64'h884cfa59ca342b2e);
        apply_writes();
        send_block('0);
        send_block('1);
        send_block({1'b1, {(BLK_W-1){1'b0}}});
        send_block(t_blk'(1));
        send_block({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        send_block(128'h0123456789abcdeffedcba9876543210);

        // only the low half changes, the high half stays as written
        plan_write(REG_KEY_LOW, 64'h0000000000000001);
        apply_writes();
        send_block('1);
        send_block(128'h00000000000000010000000000000000);

        // writes to undecoded indexes must leave the key alone
        plan_write(REG_SPARE_2, '1);
        plan_write(REG_SPARE_3, 64'h0123456789abcdef);
        apply_writes();
        send_block('1);
        send_block(random_wide());

        // zero key: every product is zero
        plan_write(REG_KEY_HIGH, '0);
        plan_write(REG_KEY_LOW, '0);
        apply_writes();
        send_block('1);
        send_block(random_wide());

        // all-ones key
        plan_write(REG_KEY_HIGH, '1);
        plan_write(REG_KEY_LOW, '1);
        apply_writes();
        send_block('1);
        send_block(random_wide());

        // key with only the last bit set: the first table step already reduces
        plan_write(REG_KEY_HIGH, '0);
        plan_write(REG_KEY_LOW, 64'h0000000000000001);
        apply_writes();
        send_block('1);
        send_block(random_wide());

        // random phases, each under a fresh key; one phase runs without gaps
        for (int p = 0; p < KEY_PHASES; p++) begin
            quiet = 1'b0;
            new_key_phase();
            quiet = (p == QUIET_PHASE);
            repeat (RANDOM_BLOCKS / KEY_PHASES) send_block(random_block());
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && products_seen == blocks_sent) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ghm_pkg.sv
sv/ghm_if.sv
sv/ghash_gf128_multiplier_unit.sv
sv/ghm_checker.sv
tb/ghm_product_checker.sv
tb/tb.sv
